/* hdl/jls_pkg.sv */
// shared constants, codes and controller/datapath types of the jacobi solver
package jls_pkg;

  localparam int unsigned MaxRows  = 128;
  localparam int unsigned MaxCols  = 128;
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned CellAddrW = RowW + ColW;
  localparam int unsigned MemAddrW = CellAddrW + 1;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DimW     = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned PaddrW   = 4;

  localparam logic [DimW-1:0] RowsReset  = DimW'(100);
  localparam logic [DimW-1:0] ColsReset  = DimW'(100);
  localparam logic [DataW-1:0] TolReset  = DataW'(17);
  localparam logic [CountW-1:0] LimReset = CountW'(100);

  typedef enum logic [KindW-1:0] {
    KIND_LOAD = 2'd0,
    KIND_READ = 2'd1,
    KIND_RUN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_TOL  = 2'd2,
    REG_LIM  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    RD_ITEM = 3'd0,
    RD_C    = 3'd1,
    RD_L    = 3'd2,
    RD_R    = 3'd3,
    RD_U    = 3'd4,
    RD_D    = 3'd5
  } rd_sel_e;

  typedef struct packed {
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_item;
    logic    wr_copy;
    logic    wr_new;
    logic    center_ld;
    logic    acc_ld;
    logic    acc_add;
    logic    mag_ld;
    logic    big_upd;
    logic    cell_next;
    logic    run_start;
    logic    sweep_done;
    logic    sweep_again;
    logic    run_end;
    logic    rdv_ld;
    logic    rdv_clr;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic last_cell;
    logic more;
  } status_t;

endpackage

/* hdl/jls_in_if.sv */
// input channel: load, read and run transactions
interface jls_in_if import jls_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KindW-1:0]        kind;
  logic [RowW-1:0]         row;
  logic [ColW-1:0]         col;
  logic signed [DataW-1:0] cell_value;

  modport source (output valid, kind, row, col, cell_value, input ready);
  modport sink (input valid, kind, row, col, cell_value, output ready);
endinterface

/* hdl/jls_out_if.sv */
// output channel: one result transaction per input transaction
interface jls_out_if import jls_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] read_value;
  logic [CountW-1:0]       sweeps_done;
  logic [DataW-1:0]        largest_change;
  logic                    converged;

  modport source (output valid, read_value, sweeps_done, largest_change, converged,
                  input ready);
  modport sink (input valid, read_value, sweeps_done, largest_change, converged,
                output ready);
endinterface

/* hdl/jls_ctrl.sv */
// controller state machine sequencing transactions and sweeps
module jls_ctrl import jls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [KindW-1:0] in_kind_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  status_t          status_i,
  output cmd_t             cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_ITEM_RD = 13'b0000000000010,
    ST_OUT     = 13'b0000000000100,
    ST_SW_C    = 13'b0000000001000,
    ST_SW_CP   = 13'b0000000010000,
    ST_SW_L    = 13'b0000000100000,
    ST_SW_R    = 13'b0000001000000,
    ST_SW_U    = 13'b0000010000000,
    ST_SW_D    = 13'b0000100000000,
    ST_SW_SUM  = 13'b0001000000000,
    ST_SW_WR   = 13'b0010000000000,
    ST_SW_MAX  = 13'b0100000000000,
    ST_SW_END  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_ITEM;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_LOAD: begin
              cmd_o.wr_item = 1'b1;
              cmd_o.rdv_clr = 1'b1;
              state_d       = ST_OUT;
            end
            KIND_READ: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ITEM;
              state_d      = ST_ITEM_RD;
            end
            KIND_RUN: begin
              cmd_o.run_start = 1'b1;
              cmd_o.rdv_clr   = 1'b1;
              state_d         = ST_SW_C;
            end
            default: begin
              cmd_o.rdv_clr = 1'b1;
              state_d       = ST_OUT;
            end
          endcase
        end
      end
      ST_ITEM_RD: begin
        cmd_o.rdv_ld = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_SW_C: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_C;
        state_d      = status_i.interior ? ST_SW_L : ST_SW_CP;
      end
      ST_SW_CP: begin
        cmd_o.wr_copy   = 1'b1;
        cmd_o.cell_next = 1'b1;
        state_d         = status_i.last_cell ? ST_SW_END : ST_SW_C;
      end
      ST_SW_L: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RD_L;
        cmd_o.center_ld = 1'b1;
        state_d         = ST_SW_R;
      end
      ST_SW_R: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_R;
        cmd_o.acc_ld = 1'b1;
        state_d      = ST_SW_U;
      end
      ST_SW_U: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_U;
        cmd_o.acc_add = 1'b1;
        state_d       = ST_SW_D;
      end
      ST_SW_D: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_D;
        cmd_o.acc_add = 1'b1;
        state_d       = ST_SW_SUM;
      end
      ST_SW_SUM: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_SW_WR;
      end
      ST_SW_WR: begin
        cmd_o.wr_new = 1'b1;
        cmd_o.mag_ld = 1'b1;
        state_d      = ST_SW_MAX;
      end
      ST_SW_MAX: begin
        cmd_o.big_upd   = 1'b1;
        cmd_o.cell_next = 1'b1;
        state_d         = status_i.last_cell ? ST_SW_END : ST_SW_C;
      end
      ST_SW_END: begin
        cmd_o.sweep_done = 1'b1;
        if (status_i.more) begin
          cmd_o.sweep_again = 1'b1;
          state_d           = ST_SW_C;
        end else begin
          cmd_o.run_end = 1'b1;
          state_d       = ST_OUT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/jls_datapath.sv */
// grid memory, cell walker, stencil accumulator and run bookkeeping
module jls_datapath import jls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [RowW-1:0]         row_i,
  input  logic [ColW-1:0]         col_i,
  input  logic signed [DataW-1:0] cell_value_i,
  input  logic [DimW-1:0]         rows_i,
  input  logic [DimW-1:0]         cols_i,
  input  logic [DataW-1:0]        tol_i,
  input  logic [CountW-1:0]       limit_i,
  output logic signed [DataW-1:0] read_value_o,
  output logic [CountW-1:0]       sweeps_done_o,
  output logic [DataW-1:0]        largest_change_o,
  output logic                    converged_o
);

  localparam int unsigned MemDepth = 2 * MaxRows * MaxCols;
  localparam int unsigned AccW     = DataW + 2;

  logic [DataW-1:0]     mem_q [MemDepth];
  logic [DataW-1:0]     rdata_q;
  logic [MemAddrW-1:0]  rd_addr, wr_addr;
  logic [DataW-1:0]     wr_data;
  logic                 wr_en;

  logic                 sel_q;
  logic [RowW-1:0]      r_q;
  logic [ColW-1:0]      c_q;
  logic [DataW-1:0]     center_q;
  logic signed [AccW-1:0] acc_q;
  logic [DataW:0]       mag_q;
  logic [DataW-1:0]     big_q;
  logic [CountW-1:0]    count_q;
  logic [DataW-1:0]     last_change_q;
  logic                 conv_q;
  logic signed [DataW-1:0] rdv_q;

  logic [DimW-1:0]      nr, nc;
  logic [DataW-1:0]     nv;
  logic signed [DataW:0] diff;
  logic [DataW:0]       mag;
  logic [CountW-1:0]    count_inc;

  assign nr = (rows_i > DimW'(MaxRows)) ? DimW'(MaxRows) : rows_i;
  assign nc = (cols_i > DimW'(MaxCols)) ? DimW'(MaxCols) : cols_i;

  assign status_o.interior  = (r_q != '0) && (c_q != '0)
                            && ((DimW'(r_q) + DimW'(1)) < nr)
                            && ((DimW'(c_q) + DimW'(1)) < nc);
  assign status_o.last_cell = (&r_q) && (&c_q);
  assign count_inc          = count_q + CountW'(1);
  assign status_o.more      = (big_q > tol_i) && (count_inc < limit_i);

  // floor of sum / 4, kept to 32 bits
  assign nv   = acc_q[AccW-1:2];
  assign diff = $signed({nv[DataW-1], nv}) - $signed({center_q[DataW-1], center_q});
  assign mag  = diff[DataW] ? (DataW+1)'(-diff) : diff;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ITEM: rd_addr = {sel_q, row_i, col_i};
      RD_C:    rd_addr = {sel_q, r_q, c_q};
      RD_L:    rd_addr = {sel_q, r_q, c_q - ColW'(1)};
      RD_R:    rd_addr = {sel_q, r_q, c_q + ColW'(1)};
      RD_U:    rd_addr = {sel_q, r_q - RowW'(1), c_q};
      RD_D:    rd_addr = {sel_q, r_q + RowW'(1), c_q};
      default: rd_addr = {sel_q, r_q, c_q};
    endcase
  end

  always_comb begin
    wr_en   = cmd_i.wr_item | cmd_i.wr_copy | cmd_i.wr_new;
    wr_addr = {~sel_q, r_q, c_q};
    wr_data = nv;
    if (cmd_i.wr_item) begin
      wr_addr = {sel_q, row_i, col_i};
      wr_data = cell_value_i;
    end else if (cmd_i.wr_copy) begin
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.center_ld) begin
      center_q <= rdata_q;
    end
    if (cmd_i.acc_ld) begin
      acc_q <= AccW'($signed(rdata_q));
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AccW'($signed(rdata_q));
    end
    if (cmd_i.mag_ld) begin
      mag_q <= mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q         <= 1'b0;
      r_q           <= '0;
      c_q           <= '0;
      big_q         <= '0;
      count_q       <= '0;
      last_change_q <= '0;
      conv_q        <= 1'b0;
      rdv_q         <= '0;
    end else begin
      if (cmd_i.run_start) begin
        r_q     <= '0;
        c_q     <= '0;
        big_q   <= '0;
        count_q <= '0;
      end
      if (cmd_i.cell_next) begin
        c_q <= c_q + ColW'(1);
        if (&c_q) begin
          r_q <= r_q + RowW'(1);
        end
      end
      if (cmd_i.big_upd) begin
        // saturate at the top of the 32-bit range
        if (mag_q[DataW]) begin
          big_q <= '1;
        end else if (mag_q[DataW-1:0] > big_q) begin
          big_q <= mag_q[DataW-1:0];
        end
      end
      if (cmd_i.sweep_done) begin
        sel_q   <= ~sel_q;
        count_q <= count_inc;
      end
      if (cmd_i.sweep_again) begin
        big_q <= '0;
      end
      if (cmd_i.run_end) begin
        last_change_q <= big_q;
        conv_q        <= (big_q <= tol_i);
      end
      if (cmd_i.rdv_clr) begin
        rdv_q <= '0;
      end else if (cmd_i.rdv_ld) begin
        rdv_q <= rdata_q;
      end
    end
  end

  assign read_value_o     = rdv_q;
  assign sweeps_done_o    = count_q;
  assign largest_change_o = last_change_q;
  assign converged_o      = conv_q;

endmodule

/* hdl/jacobi_laplace_stencil_solver.sv */
// top level of the jacobi laplace stencil solver with register port
//
//  port        dir   transaction
//  in_ch       sink  load cell, read cell or run solver
//  out_ch      src   one result per input transaction
//  apb         sink  config register writes and reads
//
// load and unused kinds go straight to output, read passes a memory read state
// a run walks all 128x128 cells per sweep through one read port of the grid
// memory: interior cells get the stencil update, other cells are copied
// one transaction in flight; the result holds until out_ch is ready
// reset clears control and result state, grid memory is undefined until loaded
module jacobi_laplace_stencil_solver import jls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  jls_in_if.sink            in_ch,
  jls_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DimW-1:0]   rows_q, cols_q;
  logic [DataW-1:0]  tol_q;
  logic [CountW-1:0] lim_q;
  reg_e              reg_idx;
  cmd_t              cmd;
  status_t           status;

  assign reg_idx = reg_e'(paddr[PaddrW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
      cols_q <= ColsReset;
      tol_q  <= TolReset;
      lim_q  <= LimReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ROWS: rows_q <= pwdata[DimW-1:0];
        REG_COLS: cols_q <= pwdata[DimW-1:0];
        REG_TOL:  tol_q  <= pwdata;
        REG_LIM:  lim_q  <= pwdata[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS: prdata = 32'(rows_q);
      REG_COLS: prdata = 32'(cols_q);
      REG_TOL:  prdata = tol_q;
      REG_LIM:  prdata = 32'(lim_q);
      default:  prdata = '0;
    endcase
  end

  jls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_kind_i   (in_ch.kind),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  jls_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .row_i            (in_ch.row),
    .col_i            (in_ch.col),
    .cell_value_i     (in_ch.cell_value),
    .rows_i           (rows_q),
    .cols_i           (cols_q),
    .tol_i            (tol_q),
    .limit_i          (lim_q),
    .read_value_o     (out_ch.read_value),
    .sweeps_done_o    (out_ch.sweeps_done),
    .largest_change_o (out_ch.largest_change),
    .converged_o      (out_ch.converged)
  );

endmodule
